FILE: rtl/jcn_pkg.sv
// Shared types and constants for the joystick calibration and normalization block.
package jcn_pkg;

  localparam int SAMPLE_W = 10;
  localparam int VAL_W    = SAMPLE_W + 2;
  localparam int QUO_W    = 7;
  localparam int REM_W    = SAMPLE_W + QUO_W;
  localparam int PCT_W    = 8;
  localparam int SH_W     = $clog2(QUO_W);
  localparam int TOL_W    = 8;

  localparam logic [TOL_W-1:0]        TOL_RESET = TOL_W'(25);
  localparam logic signed [PCT_W-1:0] PCT_POS   = PCT_W'(100);
  localparam logic signed [PCT_W-1:0] PCT_NEG   = -PCT_W'(100);
  localparam logic [REM_W-1:0]        PCT_SCALE = REM_W'(100);
  localparam logic [SH_W-1:0]         SH_TOP    = SH_W'(QUO_W - 1);

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_STOP   = 2'd2,
    FUNC_CENTER = 2'd3
  } func_t;

  localparam int CFG_AW = 3;
  localparam logic REG_TOL = 1'b0;

  typedef struct packed {
    logic            upd;
    logic            load;
    logic            step;
    logic            save;
    logic            emit;
    logic            axis;
    logic [SH_W-1:0] shamt;
  } cmd_t;

endpackage

FILE: rtl/jcn_ctrl.sv
// Sequencer that steps the datapath through update, two axis mappings and result hand-off.
module jcn_ctrl import jcn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic out_busy,
  output logic in_stall,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SAVE,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic            axis_r, axis_nxt;
  logic [SH_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.shamt = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.upd   = 1'b1;
          axis_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = SH_TOP;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_SAVE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_SAVE: begin
        cmd.save = 1'b1;
        if (axis_r) begin
          state_nxt = ST_EMIT;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  a_div_ends_in_save: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> (state_r == ST_SAVE))
    else $error("divider did not finish into save");

  a_two_axes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAVE && !axis_r) |=> (state_r == ST_LOAD && axis_r))
    else $error("Y axis mapping not started after X");

endmodule

FILE: rtl/jcn_dp.sv
// Datapath: axis state, calibration extremes, range classification and serial divider.
module jcn_dp import jcn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic [1:0]              func,
  input  logic [SAMPLE_W-1:0]     sample,
  input  logic [TOL_W-1:0]        tol,
  output logic signed [PCT_W-1:0] x_pct,
  output logic signed [PCT_W-1:0] y_pct,
  output logic                    tracking,
  output logic                    axis_sel
);

  logic [SAMPLE_W-1:0] last_x_r, last_y_r, min_x_r, max_x_r, ctr_x_r;
  logic [SAMPLE_W-1:0] min_y_r, max_y_r, ctr_y_r;
  logic                axis_r, track_r;

  logic [REM_W-1:0]        rem_r;
  logic [SAMPLE_W-1:0]     den_r;
  logic [QUO_W-1:0]        q_r;
  logic                    below_r, fixed_r;
  logic signed [PCT_W-1:0] fixval_r;
  logic signed [PCT_W-1:0] x_pct_r, y_pct_r;

  logic signed [VAL_W-1:0] sv, smn, smx, sc, st, den_s;
  logic                    dead, lo_sat, hi_sat, below, nonpos;
  logic [SAMPLE_W-1:0]     numer;
  logic [VAL_W-1:0]        numer_full;
  logic [REM_W-1:0]        prod, shd;
  logic                    ge;
  logic signed [PCT_W-1:0] res;
  func_t                   fn;

  assign fn = func_t'(func);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= 1'b0;
      track_r  <= 1'b0;
      last_x_r <= '0;
      last_y_r <= '0;
      min_x_r  <= '1;
      min_y_r  <= '1;
      max_x_r  <= '0;
      max_y_r  <= '0;
      ctr_x_r  <= '0;
      ctr_y_r  <= '0;
    end else if (cmd.upd) begin
      case (fn)
        FUNC_SAMPLE: begin
          axis_r <= ~axis_r;
          if (!axis_r) begin
            last_x_r <= sample;
            if (track_r && sample < min_x_r) min_x_r <= sample;
            if (track_r && sample > max_x_r) max_x_r <= sample;
          end else begin
            last_y_r <= sample;
            if (track_r && sample < min_y_r) min_y_r <= sample;
            if (track_r && sample > max_y_r) max_y_r <= sample;
          end
        end
        FUNC_START: begin
          min_x_r <= '1;
          min_y_r <= '1;
          max_x_r <= '0;
          max_y_r <= '0;
          ctr_x_r <= '0;
          ctr_y_r <= '0;
          track_r <= 1'b1;
        end
        FUNC_STOP: begin
          track_r <= 1'b0;
        end
        FUNC_CENTER: begin
          ctr_x_r <= last_x_r;
          ctr_y_r <= last_y_r;
          track_r <= 1'b0;
        end
        default: begin
          track_r <= track_r;
        end
      endcase
    end
  end

  always_comb begin
    sv  = $signed({2'b00, (cmd.axis ? last_y_r : last_x_r)});
    smn = $signed({2'b00, (cmd.axis ? min_y_r : min_x_r)});
    smx = $signed({2'b00, (cmd.axis ? max_y_r : max_x_r)});
    sc  = $signed({2'b00, (cmd.axis ? ctr_y_r : ctr_x_r)});
    st  = $signed({{(VAL_W-TOL_W){1'b0}}, tol});
    dead   = (sv > sc - st) && (sv < sc + st);
    lo_sat = sv < smn + st;
    hi_sat = sv > smx - st;
    below  = sv < sc;
    den_s  = below ? (sc - smn) : (smx - sc);
    nonpos = den_s <= $signed(VAL_W'(0));
    numer_full = below ? VAL_W'(sv - smn) : VAL_W'(sv - sc);
    numer  = numer_full[SAMPLE_W-1:0];
    prod   = REM_W'({{QUO_W{1'b0}}, numer} * PCT_SCALE);
    shd    = REM_W'({{QUO_W{1'b0}}, den_r} << cmd.shamt);
    ge     = rem_r >= shd;
    if (fixed_r) begin
      res = fixval_r;
    end else if (below_r) begin
      res = PCT_NEG + $signed({1'b0, q_r});
    end else begin
      res = $signed({1'b0, q_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r   <= prod;
      den_r   <= den_s[SAMPLE_W-1:0];
      q_r     <= '0;
      below_r <= below;
      fixed_r <= dead || lo_sat || hi_sat || nonpos;
      if (dead) begin
        fixval_r <= '0;
      end else if (lo_sat) begin
        fixval_r <= PCT_NEG;
      end else if (hi_sat) begin
        fixval_r <= PCT_POS;
      end else begin
        fixval_r <= below ? PCT_NEG : PCT_POS;
      end
    end else if (cmd.step) begin
      if (ge) rem_r <= rem_r - shd;
      q_r <= {q_r[QUO_W-2:0], ge};
    end
    if (cmd.save) begin
      if (cmd.axis) begin
        y_pct_r <= res;
      end else begin
        x_pct_r <= res;
      end
    end
  end

  assign x_pct    = x_pct_r;
  assign y_pct    = y_pct_r;
  assign tracking = track_r;
  assign axis_sel = axis_r;

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.save |-> (res >= PCT_NEG && res <= PCT_POS))
    else $error("mapped value out of range");

endmodule

FILE: rtl/joystick_calibrate_normalize.sv
// Top level of the joystick calibration and normalization block.
// Each accepted word (a converter sample or a calibration command) yields one result
// word when the output is free: an update step refreshes the axis state, then each
// axis passes through the shared restoring divider (load, seven quotient bits, store),
// and a final step moves the result into the output register. A new word is taken
// once the previous one has reached the output register, even if that result is still
// waiting to be taken. The tolerance register sits at byte address 0 of the
// configuration port and resets to 25.
module joystick_calibrate_normalize import jcn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_func,
  input  logic [SAMPLE_W-1:0]     in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PCT_W-1:0] out_x_percent,
  output logic signed [PCT_W-1:0] out_y_percent,
  output logic                    out_calibrating_now,
  output logic                    out_next_axis,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_AW-1:0]       cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  cmd_t                    cmd;
  logic [TOL_W-1:0]        tol_r;
  logic                    out_valid_r;
  logic signed [PCT_W-1:0] x_pct, y_pct;
  logic                    tracking, axis_sel;
  logic                    out_busy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1] == REG_TOL) ? {{(32-TOL_W){1'b0}}, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_AW-1] == REG_TOL) begin
      tol_r <= cfg_pwdata[TOL_W-1:0];
    end
  end

  assign out_busy = out_valid_r && out_stall;

  jcn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  jcn_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .func     (in_func),
    .sample   (in_sample),
    .tol      (tol_r),
    .x_pct    (x_pct),
    .y_pct    (y_pct),
    .tracking (tracking),
    .axis_sel (axis_sel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_percent       <= x_pct;
      out_y_percent       <= y_pct;
      out_calibrating_now <= tracking;
      out_next_axis       <= axis_sel;
    end
  end

  assign out_valid = out_valid_r;

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && out_stall))
    else $error("result overwrote a word still waiting");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off while an item is mapped");

endmodule
